// ----- rtl/core/hlac_pkg.sv -----
// Shared types, codes and constants for the lag-1 autocorrelation Hurst estimator.
package hlac_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int HURST_W         = 16;
  localparam int QBITS           = 31;
  localparam int FRAC_BITS       = 13;
  localparam int HALF_Q          = 2048;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_VAR = 2'd1,
    STAT_LOG_ARG  = 2'd2,
    STAT_SHORT    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_item_t;

  typedef struct packed {
    logic signed [HURST_W-1:0] hurst;
    status_t                   status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_STORE,
    ST_CHECK,
    ST_NORM,
    ST_DIV,
    ST_SQR,
    ST_SQRB,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_SQ_SUM,
    OP_CENTER_Q,
    OP_A0,
    OP_N_SQ,
    OP_A1_P,
    OP_SN,
    OP_A1_CROSS,
    OP_A1_EDGE
  } op_t;

endpackage

// ----- rtl/core/hurst_lag1_autocorrelation_top.sv -----
// Lag-1 autocorrelation Hurst estimator: accumulators, shared serial multiplier and log sequencer.
//
// Samples stream in one beat per cycle while the series runs: each beat, up to MAX_SAMPLES
// beats, updates the count, sum, sum of squares and neighbor product sum. The beat marked last
// closes the series; the block then stalls its input and runs the estimate on one shared
// shift-add multiplier that retires one multiplier bit per cycle. Eight such products, each
// with a multiplier operand of 2*CW+SAMPLE_BITS+2 bits (CW = clog2(MAX_SAMPLES+1)), form
// N^2 times the lag-0 and lag-1 autocovariances exactly; a leading-one normalization, a
// restoring divide for a 31-bit quotient and a log2 fraction of 13 bits, one per squaring
// step, then follow. An error status skips the normalization, divide and log. When the
// estimate is done, one result beat is offered and all series state clears. A finished
// result waits in the output register while the next series starts. Any status other
// than ok reports hurst at its minimum value.
module hurst_lag1_autocorrelation_top
  import hlac_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Counter width and the widths of the running sums follow from the series length.
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int S_W  = SAMPLE_BITS + CW;
  localparam int Q_W  = 2 * SAMPLE_BITS + CW;
  // Multiplier operand width covers N*N and F+L-2S; the working width covers N^2*P.
  localparam int B_W  = 2 * CW + SAMPLE_BITS + 2;
  localparam int W    = 3 * CW + 2 * SAMPLE_BITS + 4;
  localparam int E_W  = $clog2(W) + 2;
  localparam int BC_W = $clog2(B_W + 1);
  localparam int H_W  = E_W + FRAC_BITS + 2;
  localparam int L_W  = E_W + FRAC_BITS;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  // Series accumulators.
  logic        [CW-1:0]          cnt_r, cnt_nxt;
  logic signed [S_W-1:0]         sum_r, sum_nxt;
  logic        [Q_W-1:0]         sqsum_r, sqsum_nxt;
  logic signed [Q_W-1:0]         prod_r, prod_nxt;
  logic signed [SAMPLE_BITS-1:0] first_r, first_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;

  // Shared serial multiplier: acc + ma * mb, one bit of mb per cycle.
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    ma_r, ma_nxt;
  logic [B_W-1:0]  mb_r, mb_nxt;
  logic [BC_W-1:0] step_r, step_nxt;

  // Intermediate products.
  logic [W-1:0] s2_r, s2_nxt;
  logic [W-1:0] tmp_r, tmp_nxt;
  logic [W-1:0] a0_r, a0_nxt;
  logic [W-1:0] a1_r, a1_nxt;

  // Divider and log stage.
  logic        [W:0]             n_r, n_nxt;
  logic        [W:0]             d_r, d_nxt;
  logic        [E_W-1:0]         en_r, en_nxt;
  logic        [E_W-1:0]         ed_r, ed_nxt;
  logic signed [E_W-1:0]         e_r, e_nxt;
  logic        [QBITS-1:0]       x_r, x_nxt;
  logic        [2*QBITS-1:0]     sqp_r, sqp_nxt;
  logic        [FRAC_BITS-1:0]   frac_r, frac_nxt;
  status_t                       stat_r, stat_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic                           in_acc;
  logic                           out_free;
  logic                           mul_last;
  logic                           norm_done;
  logic                           div_ge;
  logic signed [2*SAMPLE_BITS-1:0] x_sq;
  logic signed [2*SAMPLE_BITS-1:0] x_nb;
  logic signed [B_W-1:0]          cross_b;
  logic signed [W-1:0]            num_w;
  logic        [QBITS:0]          tq;
  logic signed [L_W-1:0]          lq;
  logic signed [H_W-1:0]          h_t;
  logic signed [H_W-1:0]          h_w;
  logic signed [HURST_W-1:0]      h_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mul_last  = (step_r == BC_W'(B_W - 1));
  assign norm_done = n_r[W-1] && d_r[W-1];
  assign div_ge    = (n_r >= d_r);
  assign x_sq      = in_data.sample * in_data.sample;
  assign x_nb      = prev_r * in_data.sample;
  assign cross_b   = B_W'(first_r) + B_W'(prev_r) - (B_W'(sum_r) <<< 1);
  assign num_w     = $signed(a0_r) + $signed(a1_r);
  assign tq        = sqp_r[2*QBITS-1:QBITS-1];

  // Log value is the exponent followed by the fraction bits; round half up by two places.
  assign lq    = $signed({e_r, frac_r});
  assign h_t   = H_W'(lq) + H_W'(2);
  assign h_w   = (h_t >>> 2) + H_W'(HALF_Q);
  always_comb begin
    if (h_w > H_W'(32767)) begin
      h_sat = 16'sh7FFF;
    end else if (h_w < -H_W'(32768)) begin
      h_sat = 16'sh8000;
    end else begin
      h_sat = h_w[HURST_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_last) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: state_nxt = (op_r == OP_A1_EDGE) ? ST_CHECK : ST_LOAD;
      ST_CHECK: begin
        if (cnt_r < CW'(2) || $signed(a0_r) <= 0 || num_w <= 0) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == BC_W'(QBITS - 1)) begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: state_nxt = ST_SQRB;
      ST_SQRB: state_nxt = (step_r == BC_W'(FRAC_BITS - 1)) ? ST_FIN : ST_SQR;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    sqsum_nxt     = sqsum_r;
    prod_nxt      = prod_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    step_nxt      = step_r;
    s2_nxt        = s2_r;
    tmp_nxt       = tmp_r;
    a0_nxt        = a0_r;
    a1_nxt        = a1_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    en_nxt        = en_r;
    ed_nxt        = ed_r;
    e_nxt         = e_r;
    x_nxt         = x_r;
    sqp_nxt       = sqp_r;
    frac_nxt      = frac_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_r < CW'(MAX_SAMPLES)) begin
            if (cnt_r == '0) begin
              first_nxt = in_data.sample;
            end else begin
              prod_nxt = prod_r + Q_W'(x_nb);
            end
            sum_nxt   = sum_r + S_W'(in_data.sample);
            sqsum_nxt = sqsum_r + Q_W'($unsigned(x_sq));
            prev_nxt  = in_data.sample;
            cnt_nxt   = cnt_r + CW'(1);
          end
          op_nxt = OP_SQ_SUM;
        end
      end
      ST_LOAD: begin
        step_nxt = '0;
        acc_nxt  = '0;
        ma_nxt   = '0;
        mb_nxt   = B_W'(cnt_r);
        case (op_r)
          OP_SQ_SUM: begin
            ma_nxt = W'(sum_r);
            mb_nxt = B_W'(sum_r);
          end
          OP_CENTER_Q: begin
            acc_nxt = W'(-$signed(s2_r));
            ma_nxt  = W'(sqsum_r);
          end
          OP_A0:   ma_nxt = tmp_r;
          OP_N_SQ: ma_nxt = W'(cnt_r);
          OP_A1_P: begin
            ma_nxt = W'(prod_r);
            mb_nxt = tmp_r[B_W-1:0];
          end
          OP_SN: ma_nxt = W'(sum_r);
          OP_A1_CROSS: begin
            acc_nxt = a1_r;
            ma_nxt  = tmp_r;
            mb_nxt  = cross_b;
          end
          OP_A1_EDGE: begin
            acc_nxt = a1_r;
            ma_nxt  = s2_r;
            mb_nxt  = B_W'(cnt_r) - B_W'(1);
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        // The top bit of the multiplier carries negative weight.
        if (mb_r[0]) begin
          acc_nxt = mul_last ? (acc_r - ma_r) : (acc_r + ma_r);
        end
        ma_nxt   = ma_r << 1;
        mb_nxt   = mb_r >> 1;
        step_nxt = step_r + BC_W'(1);
      end
      ST_STORE: begin
        case (op_r)
          OP_SQ_SUM: s2_nxt  = acc_r;
          OP_A0:     a0_nxt  = acc_r;
          OP_A1_P, OP_A1_CROSS, OP_A1_EDGE: a1_nxt = acc_r;
          default:   tmp_nxt = acc_r;
        endcase
        op_nxt = op_t'(op_r + 3'd1);
      end
      ST_CHECK: begin
        stat_nxt = STAT_OK;
        if (cnt_r < CW'(2)) begin
          stat_nxt = STAT_SHORT;
        end else if ($signed(a0_r) <= 0) begin
          stat_nxt = STAT_ZERO_VAR;
        end else if (num_w <= 0) begin
          stat_nxt = STAT_LOG_ARG;
        end
        n_nxt    = {1'b0, num_w};
        d_nxt    = {1'b0, a0_r};
        en_nxt   = '0;
        ed_nxt   = '0;
        x_nxt    = '0;
        frac_nxt = '0;
      end
      ST_NORM: begin
        if (norm_done) begin
          if (n_r < d_r) begin
            n_nxt = n_r << 1;
            e_nxt = $signed(ed_r - en_r) - E_W'(1);
          end else begin
            e_nxt = $signed(ed_r - en_r);
          end
          step_nxt = '0;
        end else begin
          if (!n_r[W-1]) begin
            n_nxt  = n_r << 1;
            en_nxt = en_r + E_W'(1);
          end
          if (!d_r[W-1]) begin
            d_nxt  = d_r << 1;
            ed_nxt = ed_r + E_W'(1);
          end
        end
      end
      ST_DIV: begin
        n_nxt    = (div_ge ? (n_r - d_r) : n_r) << 1;
        x_nxt    = {x_r[QBITS-2:0], div_ge};
        step_nxt = (step_r == BC_W'(QBITS - 1)) ? '0 : step_r + BC_W'(1);
      end
      ST_SQR: sqp_nxt = x_r * x_r;
      ST_SQRB: begin
        if (tq[QBITS]) begin
          x_nxt = tq[QBITS:1];
        end else begin
          x_nxt = tq[QBITS-1:0];
        end
        frac_nxt = {frac_r[FRAC_BITS-2:0], tq[QBITS]};
        step_nxt = step_r + BC_W'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = stat_r;
          out_data_nxt.hurst  = (stat_r == STAT_OK) ? h_sat : 16'sh8000;
          cnt_nxt             = '0;
          sum_nxt             = '0;
          sqsum_nxt           = '0;
          prod_nxt            = '0;
          first_nxt           = '0;
          prev_nxt            = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SQ_SUM;
      cnt_r       <= '0;
      sum_r       <= '0;
      sqsum_r     <= '0;
      prod_r      <= '0;
      first_r     <= '0;
      prev_r      <= '0;
      step_r      <= '0;
      stat_r      <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      sqsum_r     <= sqsum_nxt;
      prod_r      <= prod_nxt;
      first_r     <= first_nxt;
      prev_r      <= prev_nxt;
      step_r      <= step_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    s2_r       <= s2_nxt;
    tmp_r      <= tmp_nxt;
    a0_r       <= a0_nxt;
    a1_r       <= a1_nxt;
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    en_r       <= en_nxt;
    ed_r       <= ed_nxt;
    e_r        <= e_nxt;
    x_r        <= x_nxt;
    sqp_r      <= sqp_nxt;
    frac_r     <= frac_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new result beat appears only when the sequencer finishes an estimate.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result beat raised outside the finish step");

  // Any error status carries the minimum estimate.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != STAT_OK |-> out_data_r.hurst == 16'sh8000)
    else $error("error status with a non-minimum estimate");

  // The sample count never passes the series limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SAMPLES))
    else $error("sample count beyond the series limit");

  // The accumulators are cleared after every estimate handed out.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_free |=> cnt_r == '0 && state_r == ST_IDLE)
    else $error("series state not cleared after an estimate");

endmodule
